// ===== rtl/core/dbwe_pkg.sv =====
`default_nettype none

package dbwe_pkg;

    // Configuration register indexes.
    localparam logic [1:0] CFG_TICK_LENGTH   = 2'd0;
    localparam logic [1:0] CFG_TARGET_DELAY  = 2'd1;
    localparam logic [1:0] CFG_EWMA_GAIN     = 2'd2;
    localparam logic [1:0] CFG_BIAS_STEP     = 2'd3;

    // Reset values of the configuration registers.
    localparam logic [9:0]  TICK_LENGTH_RST  = 10'd30;
    localparam logic [9:0]  TARGET_DELAY_RST = 10'd170;
    localparam logic [8:0]  EWMA_GAIN_RST    = 9'd51;
    localparam logic [15:0] BIAS_STEP_RST    = 16'd655;

    // Operand selection codes for the shared divider.
    localparam logic [1:0] DIV_SEL_FLOOR  = 2'd0;
    localparam logic [1:0] DIV_SEL_SAMPLE = 2'd1;
    localparam logic [1:0] DIV_SEL_ALIGN  = 2'd2;

    // Delay used when the receiver timestamp is not after the send timestamp.
    localparam logic [31:0] REVERSED_DELAY_MS = 32'd252525;
    localparam logic [15:0] COUNT_MAX         = 16'hFFFF;
    localparam logic [8:0]  GAIN_ONE          = 9'd256;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic       in_load;
        logic       div_start;
        logic [1:0] div_sel;
        logic       floor_load;
        logic       sample_load;
        logic       align_load;
        logic       ewma_mul;
        logic       ewma_upd;
        logic       ack_inc;
        logic       win_factor;
        logic       win_scale;
        logic       win_hi;
        logic       win_lo;
        logic       win_sum;
        logic       out_load;
    } dbwe_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic tick_end;
        logic div_busy;
        logic div_done;
        logic out_valid;
    } dbwe_status_t;

endpackage

`default_nettype wire

// ===== rtl/core/dbwe_div.sv =====
`default_nettype none

module dbwe_div
    import dbwe_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        start,
    input  wire logic [31:0] dividend,
    input  wire logic [31:0] divisor,
    output logic             busy,
    output logic             done,
    output logic [31:0]      quotient,
    output logic [31:0]      remainder
);

    logic        busy_reg;
    logic        done_reg;
    logic [4:0]  cnt_reg;
    logic [31:0] quot_reg;
    logic [31:0] rem_reg;
    logic [31:0] divisor_reg;
    logic [32:0] rem_shift;
    logic [32:0] rem_diff;

    // One restoring step: shift in the next dividend bit and try a subtract.
    assign rem_shift = {rem_reg, quot_reg[31]};
    assign rem_diff  = rem_shift - {1'b0, divisor_reg};

    // Control: 32 steps after a start, then a one-cycle done pulse.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= 5'd0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= 5'd0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 5'd1;
                if (cnt_reg == 5'd31)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // Datapath of the divider.
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            quot_reg    <= dividend;
            rem_reg     <= 32'd0;
            divisor_reg <= divisor;
        end
        else if (busy_reg)
        begin
            if (!rem_diff[32])
            begin
                rem_reg  <= rem_diff[31:0];
                quot_reg <= {quot_reg[30:0], 1'b1};
            end
            else
            begin
                rem_reg  <= rem_shift[31:0];
                quot_reg <= {quot_reg[30:0], 1'b0};
            end
        end
    end

    assign busy      = busy_reg;
    assign done      = done_reg;
    assign quotient  = quot_reg;
    assign remainder = rem_reg;

endmodule

`default_nettype wire

// ===== rtl/core/dbwe_dp.sv =====
`default_nettype none

module dbwe_dp
    import dbwe_pkg::*;
(
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire dbwe_cmd_t    cmd,
    output dbwe_status_t      st,
    input  wire logic         cfg_valid,
    input  wire logic [1:0]   cfg_index,
    input  wire logic [15:0]  cfg_data,
    input  wire logic         command,
    input  wire logic [31:0]  event_time,
    input  wire logic [31:0]  acked_send_time,
    input  wire logic [31:0]  acked_recv_time,
    input  wire logic         out_ready,
    output logic              out_valid,
    output logic [15:0]       window_datagrams
);

    // Configuration registers.
    logic [9:0]  tick_len_reg;
    logic [9:0]  target_reg;
    logic [8:0]  gain_reg;
    logic [15:0] bias_reg;

    // Captured item.
    logic        cmd_reg;
    logic [31:0] now_reg;
    logic [31:0] delay_reg;

    // Estimator state.
    logic [15:0] acks_reg;
    logic [31:0] tick_start_reg;
    logic [31:0] thr_reg;
    logic [15:0] above_reg;
    logic [15:0] below_reg;

    // Intermediate results.
    logic [16:0] floor_reg;
    logic [31:0] sample_reg;
    logic [9:0]  align_reg;
    logic [40:0] p1_reg;
    logic [32:0] factor_reg;
    logic        factor_pos_reg;
    logic [41:0] scale_reg;
    logic [58:0] hi_reg;
    logic [48:0] lo_reg;
    logic [15:0] win_reg;
    logic [15:0] out_reg;
    logic        out_valid_reg;

    logic [9:0]  tick_eff;
    logic [8:0]  gain_eff;
    logic [31:0] rtt;
    logic [31:0] delay_raw;
    logic [31:0] delay_min;
    logic [31:0] elapsed;
    logic [31:0] div_dividend;
    logic [31:0] div_divisor;
    logic        div_busy;
    logic        div_done;
    logic [31:0] div_quot;
    logic [31:0] div_rem;
    logic [31:0] sample_floor;
    logic [40:0] p2;
    logic [41:0] ewma_sum;
    logic [31:0] est;
    logic [31:0] est_floor;
    logic signed [16:0] run_diff;
    logic signed [33:0] bias_prod;
    logic signed [33:0] factor;
    logic [59:0] win_acc;
    logic [43:0] win_wide;

    // Effective register values for the special cases.
    assign tick_eff = (tick_len_reg == 10'd0) ? 10'd1 : tick_len_reg;
    assign gain_eff = (gain_reg > GAIN_ONE) ? GAIN_ONE : gain_reg;

    // Configuration writes.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tick_len_reg <= TICK_LENGTH_RST;
            target_reg   <= TARGET_DELAY_RST;
            gain_reg     <= EWMA_GAIN_RST;
            bias_reg     <= BIAS_STEP_RST;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                CFG_TICK_LENGTH:  tick_len_reg <= cfg_data[9:0];
                CFG_TARGET_DELAY: target_reg   <= cfg_data[9:0];
                CFG_EWMA_GAIN:    gain_reg     <= cfg_data[8:0];
                CFG_BIAS_STEP:    bias_reg     <= cfg_data;
                default:          ;
            endcase
        end
    end

    // Delay of an ack: one-way delay capped by the round trip.
    assign rtt       = event_time - acked_send_time;
    assign delay_raw = (acked_recv_time > acked_send_time) ?
                       (acked_recv_time - acked_send_time) : REVERSED_DELAY_MS;
    assign delay_min = (delay_raw > rtt) ? rtt : delay_raw;

    // Item capture.
    always_ff @(posedge clk)
    begin
        if (cmd.in_load)
        begin
            cmd_reg   <= command;
            now_reg   <= event_time;
            delay_reg <= command ? delay_min : 32'd0;
        end
    end

    assign elapsed = now_reg - tick_start_reg;

    // Shared divider and its operand selection.
    always_comb
    begin
        case (cmd.div_sel)
            DIV_SEL_FLOOR:
            begin
                div_dividend = 32'h0001_0000;
                div_divisor  = delay_reg;
            end
            DIV_SEL_SAMPLE:
            begin
                div_dividend = {acks_reg, 16'h0000};
                div_divisor  = {22'd0, tick_eff};
            end
            DIV_SEL_ALIGN:
            begin
                div_dividend = now_reg;
                div_divisor  = {22'd0, tick_eff};
            end
            default:
            begin
                div_dividend = now_reg;
                div_divisor  = {22'd0, tick_eff};
            end
        endcase
    end

    dbwe_div u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (cmd.div_start),
        .dividend  (div_dividend),
        .divisor   (div_divisor),
        .busy      (div_busy),
        .done      (div_done),
        .quotient  (div_quot),
        .remainder (div_rem)
    );

    // Sample floored by the delay bound.
    assign sample_floor = (div_quot < {15'd0, floor_reg}) ? {15'd0, floor_reg} : div_quot;

    always_ff @(posedge clk)
    begin
        if (cmd.floor_load)
        begin
            floor_reg <= (delay_reg == 32'd0) ? 17'd0 : div_quot[16:0];
        end
        if (cmd.sample_load)
        begin
            sample_reg <= sample_floor;
        end
        if (cmd.align_load)
        begin
            align_reg <= div_rem[9:0];
        end
        if (cmd.ewma_mul)
        begin
            p1_reg <= (GAIN_ONE - gain_eff) * thr_reg;
        end
    end

    // Blend of the estimate with the new sample.
    assign p2        = gain_eff * sample_reg;
    assign ewma_sum  = {1'b0, p1_reg} + {1'b0, p2};
    assign est       = ewma_sum[39:8];
    assign est_floor = (est < {15'd0, floor_reg}) ? {15'd0, floor_reg} : est;

    // Estimator state updates.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acks_reg       <= 16'd0;
            tick_start_reg <= 32'd0;
            thr_reg        <= 32'd0;
            above_reg      <= 16'd0;
            below_reg      <= 16'd0;
        end
        else if (cmd.ewma_upd)
        begin
            thr_reg        <= est_floor;
            acks_reg       <= 16'd0;
            tick_start_reg <= now_reg - {22'd0, align_reg};
            if (sample_reg > est_floor)
            begin
                above_reg <= (above_reg == COUNT_MAX) ? COUNT_MAX : above_reg + 16'd1;
                below_reg <= 16'd0;
            end
            else
            begin
                below_reg <= (below_reg == COUNT_MAX) ? COUNT_MAX : below_reg + 16'd1;
                above_reg <= 16'd0;
            end
        end
        else if (cmd.ack_inc && cmd_reg && (acks_reg != COUNT_MAX))
        begin
            acks_reg <= acks_reg + 16'd1;
        end
    end

    // Window scale factor from the signed run difference.
    assign run_diff  = $signed({1'b0, above_reg}) - $signed({1'b0, below_reg});
    assign bias_prod = $signed({1'b0, bias_reg}) * run_diff;
    assign factor    = 34'sd65536 + bias_prod;

    // Final sum of the two partial products, then saturation.
    assign win_acc  = {1'b0, hi_reg} + {27'd0, lo_reg[48:16]};
    assign win_wide = win_acc[59:16];

    // Window pipeline, at most one multiplier per step.
    always_ff @(posedge clk)
    begin
        if (cmd.win_factor)
        begin
            factor_reg     <= factor[32:0];
            factor_pos_reg <= !factor[33] && (factor != 34'sd0);
        end
        if (cmd.win_scale)
        begin
            scale_reg <= thr_reg * target_reg;
        end
        if (cmd.win_hi)
        begin
            hi_reg <= scale_reg[41:16] * factor_reg;
        end
        if (cmd.win_lo)
        begin
            lo_reg <= scale_reg[15:0] * factor_reg;
        end
        if (cmd.win_sum)
        begin
            if (!factor_pos_reg)
            begin
                win_reg <= 16'd0;
            end
            else if (win_wide > 44'd65535)
            begin
                win_reg <= 16'hFFFF;
            end
            else
            begin
                win_reg <= win_wide[15:0];
            end
        end
        if (cmd.out_load)
        begin
            out_reg <= win_reg;
        end
    end

    // Output register valid flag.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.out_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    assign st.tick_end  = (elapsed >= {22'd0, tick_eff});
    assign st.div_busy  = div_busy;
    assign st.div_done  = div_done;
    assign st.out_valid = out_valid_reg;

    assign out_valid        = out_valid_reg;
    assign window_datagrams = out_reg;

endmodule

`default_nettype wire

// ===== rtl/core/dbwe_ctrl.sv =====
`default_nettype none

module dbwe_ctrl
    import dbwe_pkg::*;
(
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          in_valid,
    output logic               in_ready,
    input  wire logic          out_ready,
    input  wire dbwe_status_t  st,
    output dbwe_cmd_t          cmd
);

    localparam logic [3:0] S_IDLE     = 4'd0;
    localparam logic [3:0] S_CHECK    = 4'd1;
    localparam logic [3:0] S_FLOOR_GO = 4'd2;
    localparam logic [3:0] S_FLOOR_WT = 4'd3;
    localparam logic [3:0] S_SMP_GO   = 4'd4;
    localparam logic [3:0] S_SMP_WT   = 4'd5;
    localparam logic [3:0] S_ALN_GO   = 4'd6;
    localparam logic [3:0] S_ALN_WT   = 4'd7;
    localparam logic [3:0] S_EWMA1    = 4'd8;
    localparam logic [3:0] S_EWMA2    = 4'd9;
    localparam logic [3:0] S_WIN1     = 4'd10;
    localparam logic [3:0] S_WIN2     = 4'd11;
    localparam logic [3:0] S_WIN3     = 4'd12;
    localparam logic [3:0] S_WIN4     = 4'd13;
    localparam logic [3:0] S_WIN5     = 4'd14;
    localparam logic [3:0] S_OUT      = 4'd15;

    logic [3:0] state_reg;
    logic [3:0] state_next;
    logic       out_free;

    assign out_free = !st.out_valid || out_ready;

    // Next state and command decode.
    always_comb
    begin
        state_next      = state_reg;
        cmd             = '0;
        cmd.div_sel     = DIV_SEL_FLOOR;
        in_ready        = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.in_load = 1'b1;
                    state_next  = S_CHECK;
                end
            end
            S_CHECK:
            begin
                state_next = st.tick_end ? S_FLOOR_GO : S_WIN1;
            end
            S_FLOOR_GO:
            begin
                cmd.div_start = 1'b1;
                cmd.div_sel   = DIV_SEL_FLOOR;
                state_next    = S_FLOOR_WT;
            end
            S_FLOOR_WT:
            begin
                cmd.div_sel = DIV_SEL_FLOOR;
                if (st.div_done)
                begin
                    cmd.floor_load = 1'b1;
                    state_next     = S_SMP_GO;
                end
            end
            S_SMP_GO:
            begin
                cmd.div_start = 1'b1;
                cmd.div_sel   = DIV_SEL_SAMPLE;
                state_next    = S_SMP_WT;
            end
            S_SMP_WT:
            begin
                cmd.div_sel = DIV_SEL_SAMPLE;
                if (st.div_done)
                begin
                    cmd.sample_load = 1'b1;
                    state_next      = S_ALN_GO;
                end
            end
            S_ALN_GO:
            begin
                cmd.div_start = 1'b1;
                cmd.div_sel   = DIV_SEL_ALIGN;
                state_next    = S_ALN_WT;
            end
            S_ALN_WT:
            begin
                cmd.div_sel = DIV_SEL_ALIGN;
                if (st.div_done)
                begin
                    cmd.align_load = 1'b1;
                    state_next     = S_EWMA1;
                end
            end
            S_EWMA1:
            begin
                cmd.ewma_mul = 1'b1;
                state_next   = S_EWMA2;
            end
            S_EWMA2:
            begin
                cmd.ewma_upd = 1'b1;
                state_next   = S_WIN1;
            end
            S_WIN1:
            begin
                cmd.ack_inc    = 1'b1;
                cmd.win_factor = 1'b1;
                state_next     = S_WIN2;
            end
            S_WIN2:
            begin
                cmd.win_scale = 1'b1;
                state_next    = S_WIN3;
            end
            S_WIN3:
            begin
                cmd.win_hi = 1'b1;
                state_next = S_WIN4;
            end
            S_WIN4:
            begin
                cmd.win_lo = 1'b1;
                state_next = S_WIN5;
            end
            S_WIN5:
            begin
                cmd.win_sum = 1'b1;
                state_next  = S_OUT;
            end
            S_OUT:
            begin
                if (out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // State register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // The divider is never restarted while it is still iterating.
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.div_start |-> !st.div_busy)
        else $error("divider started while busy");

    // A finished division is only reported while the controller waits for one.
    assert property (@(posedge clk) disable iff (!rst_n)
        st.div_done |-> (state_reg == S_FLOOR_WT || state_reg == S_SMP_WT ||
                         state_reg == S_ALN_WT))
        else $error("divider result arrived outside a wait state");

    // A waiting result is never overwritten before it is taken.
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load |-> (!st.out_valid || out_ready))
        else $error("output register overwritten");

    // Accepting an item drops in_ready, so the next item waits for this one's result.
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.in_load |=> !in_ready)
        else $error("item accepted while previous item in flight");

endmodule

`default_nettype wire

// ===== rtl/core/delay_bounded_window_estimator_unit.sv =====
// Each item runs through the tick check and the window steps to out_valid; when a tick
// ends, three divisions on the shared radix-2 divider and the EWMA update come first.
// One item is taken at a time; the next item is taken while a result still waits, and
// a result not taken stalls the next one.
// Reset: rst_n is asynchronous and active low; it clears the estimator state and
// loads the configuration registers with their defaults.
`default_nettype none

module delay_bounded_window_estimator_unit
    import dbwe_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [15:0] cfg_data,
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic        command,
    input  wire logic [31:0] event_time,
    input  wire logic [31:0] acked_send_time,
    input  wire logic [31:0] acked_recv_time,
    output logic             out_valid,
    input  wire logic        out_ready,
    output logic [15:0]      window_datagrams
);

    dbwe_cmd_t    cmd;
    dbwe_status_t st;

    // Configuration writes are always taken.
    assign cfg_ready = 1'b1;

    dbwe_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_ready (out_ready),
        .st        (st),
        .cmd       (cmd)
    );

    dbwe_dp u_dp (
        .clk              (clk),
        .rst_n            (rst_n),
        .cmd              (cmd),
        .st               (st),
        .cfg_valid        (cfg_valid),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data),
        .command          (command),
        .event_time       (event_time),
        .acked_send_time  (acked_send_time),
        .acked_recv_time  (acked_recv_time),
        .out_ready        (out_ready),
        .out_valid        (out_valid),
        .window_datagrams (window_datagrams)
    );

endmodule

`default_nettype wire
